// ===== sv/csem_pkg.sv =====
package csem_pkg;

	localparam int MAX_WAITERS = 16;
	localparam int PTR_W = $clog2(MAX_WAITERS);
	localparam int OCC_W = $clog2(MAX_WAITERS + 1);
	localparam int CNT_W = 8;
	localparam int ID_W = 4;
	localparam int STAT_W = 3;

	localparam logic [CNT_W-1:0] CAPACITY_RESET = 8'd255;

	localparam logic OP_WAIT = 1'b0;
	localparam logic OP_POST = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_GRANTED   = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_FULL      = 3'd2,
		ST_RAISED    = 3'd3,
		ST_SATURATED = 3'd4,
		ST_RELEASED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} csem_cmd_t;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(MAX_WAITERS - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// ===== sv/csem_req_if.sv =====
interface csem_req_if import csem_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            opcode;
	logic [ID_W-1:0] requester_id;

	modport source (output valid, output opcode, output requester_id, input ready);
	modport sink (input valid, input opcode, input requester_id, output ready);
endinterface

// ===== sv/csem_rsp_if.sv =====
interface csem_rsp_if import csem_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   released_id;
	logic [CNT_W-1:0]  count_now;
	logic [OCC_W-1:0]  waiters_now;

	modport source (output valid, output status, output released_id, output count_now,
		output waiters_now, input ready);
	modport sink (input valid, input status, input released_id, input count_now,
		input waiters_now, output ready);
endinterface

// ===== sv/csem_ram.sv =====
module csem_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/csem_ctrl.sv =====
module csem_ctrl import csem_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output csem_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_RESP: rsp_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== sv/csem_dp.sv =====
module csem_dp import csem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  csem_cmd_t         cmd,
	input  logic              opcode,
	input  logic [ID_W-1:0]   requester_id,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   released_id,
	output logic [CNT_W-1:0]  count_now,
	output logic [OCC_W-1:0]  waiters_now
);

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;
	logic             op_q;
	logic [ID_W-1:0]  rid_q;
	status_t          status_q;
	logic [ID_W-1:0]  released_q;

	logic             is_wait;
	logic             has_count;
	logic             has_waiters;
	logic             has_room;
	logic             push;
	logic             pop;
	logic [ID_W-1:0]  head_data;

	assign is_wait     = (op_q == OP_WAIT);
	assign has_count   = (count_q != '0);
	assign has_waiters = (occ_q != '0);
	assign has_room    = (occ_q < OCC_W'(MAX_WAITERS));
	assign push        = cmd.exec && is_wait && !has_count && has_room;
	assign pop         = cmd.exec && !is_wait && has_waiters;

	// read port follows the head; data is settled in the cycle after any head move
	csem_ram #(
		.WIDTH (ID_W),
		.DEPTH (MAX_WAITERS)
	) u_fifo_ram (
		.clk   (clk),
		.we    (push),
		.waddr (tail_q),
		.wdata (rid_q),
		.raddr (head_q),
		.rdata (head_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			rid_q <= requester_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
		end else if (cmd.exec) begin
			if (is_wait) begin
				if (has_count) begin
					count_q <= count_q - CNT_W'(1);
				end else if (has_room) begin
					tail_q <= next_slot(tail_q);
					occ_q  <= occ_q + OCC_W'(1);
				end
			end else if (has_waiters) begin
				head_q <= next_slot(head_q);
				occ_q  <= occ_q - OCC_W'(1);
			end else if (count_q < capacity_q) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_wait) begin
				released_q <= '0;
				if (has_count) begin
					status_q <= ST_GRANTED;
				end else if (has_room) begin
					status_q <= ST_QUEUED;
				end else begin
					status_q <= ST_FULL;
				end
			end else if (has_waiters) begin
				status_q   <= ST_RELEASED;
				released_q <= head_data;
			end else begin
				released_q <= '0;
				if (count_q < capacity_q) begin
					status_q <= ST_RAISED;
				end else begin
					status_q <= ST_SATURATED;
				end
			end
		end
	end

	assign status      = status_q;
	assign released_id = released_q;
	assign count_now   = count_q;
	assign waiters_now = occ_q;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(MAX_WAITERS))
		else $error("waiter count exceeds queue depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> head_q == tail_q)
		else $error("empty queue with head and tail apart");

	a_grant_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_wait && has_count |=> count_q == CNT_W'($past(count_q) - 8'd1))
		else $error("grant did not take one unit from the count");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> occ_q == OCC_W'($past(occ_q) - 5'd1))
		else $error("release did not drop one waiter");
`endif

endmodule

// ===== sv/counting_semaphore_wait_queue.sv =====
// The controller walks accept, execute, respond for each request: a request is captured
// when accepted, applied to the count and waiter queue in execute, and its result is held
// in respond until the result side is ready; no new request is accepted before then.
// The waiter queue is a registered-read RAM whose port follows the head pointer.
// Reset (arst_n, async, active low): count 0, queue empty, capacity 255;
// queue storage is not cleared.
module counting_semaphore_wait_queue import csem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	csem_req_if.sink         req,
	csem_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	csem_cmd_t cmd;

	csem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	csem_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (req.opcode),
		.requester_id (req.requester_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.status       (rsp.status),
		.released_id  (rsp.released_id),
		.count_now    (rsp.count_now),
		.waiters_now  (rsp.waiters_now)
	);

endmodule
